@@ src/fqs_pkg.sv @@
// Shared types and constants for the FIFO queue with search and update.
// No dependencies; used by fqs_ctrl, fqs_dp and fifo_queue_with_search.
`default_nettype none

package fqs_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int REQ_W       = 3;
    localparam int DATA_W      = 32;
    localparam int POS_OUT_W   = 4;
    localparam int COUNT_OUT_W = 5;

    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEQ_WAIT,
        ST_SCAN,
        ST_FRONT_RD,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic latch;
        logic enq_write;
        logic rd_head;
        logic deq_pop;
        logic scan_start;
        logic scan_next;
        logic scan_hit;
        logic clear;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             count_zero;
        logic             full;
        logic             match;
        logic             scan_last;
    } dp_status_t;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] n;
        n = i + 1'b1;
        if (i == IDX_W'(DEPTH - 1))
        begin
            n = '0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ src/fqs_dp.sv @@
// Datapath: entry memory, head/tail/count pointers, scan position and result registers.
// Depends on fqs_pkg; driven by commands from fqs_ctrl.
`default_nettype none

module fqs_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fqs_pkg::ctrl_cmd_t              cmd,
    output fqs_pkg::dp_status_t                  status,
    input  wire logic [fqs_pkg::REQ_W-1:0]       req_type,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] value,
    input  wire logic signed [fqs_pkg::DATA_W-1:0] new_value,
    output logic                                 ok,
    output logic signed [fqs_pkg::DATA_W-1:0]    data_out,
    output logic [fqs_pkg::POS_OUT_W-1:0]        position,
    output logic signed [fqs_pkg::DATA_W-1:0]    front_value,
    output logic                                 front_valid,
    output logic [fqs_pkg::COUNT_OUT_W-1:0]      count,
    output logic                                 full_res
);
    import fqs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [REQ_W-1:0]  req_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] new_value_reg;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  slot_reg;
    logic [IDX_W-1:0]  pos_reg;

    logic              ok_reg;
    logic [DATA_W-1:0] data_reg;
    logic [IDX_W-1:0]  pos_res_reg;

    logic              out_ok_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [IDX_W-1:0]  out_pos_reg;
    logic [DATA_W-1:0] out_front_reg;
    logic              out_front_valid_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_full_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb
    begin
        rd_en   = cmd.rd_head || cmd.scan_start || cmd.scan_next;
        rd_addr = cmd.scan_next ? wrap_next(slot_reg) : head_reg;
        wr_en   = cmd.enq_write || (cmd.scan_hit && req_reg == REQ_UPDATE);
        wr_addr = cmd.enq_write ? tail_reg : slot_reg;
        wr_data = cmd.enq_write ? value_reg : new_value_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.enq_write)
        begin
            tail_next  = wrap_next(tail_reg);
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq_pop)
        begin
            head_next  = wrap_next(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg       <= req_type;
            value_reg     <= value;
            new_value_reg <= new_value;
            ok_reg        <= 1'b0;
            data_reg      <= '0;
            pos_res_reg   <= '0;
        end
        if (cmd.enq_write || cmd.clear)
        begin
            ok_reg <= 1'b1;
        end
        if (cmd.deq_pop)
        begin
            ok_reg   <= 1'b1;
            data_reg <= rd_data_reg;
        end
        if (cmd.scan_start)
        begin
            slot_reg <= head_reg;
            pos_reg  <= '0;
        end
        else if (cmd.scan_next)
        begin
            slot_reg <= wrap_next(slot_reg);
            pos_reg  <= pos_reg + 1'b1;
        end
        if (cmd.scan_hit)
        begin
            ok_reg <= 1'b1;
            if (req_reg == REQ_SEARCH)
            begin
                pos_res_reg <= pos_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_ok_reg          <= ok_reg;
            out_data_reg        <= data_reg;
            out_pos_reg         <= pos_res_reg;
            out_front_reg       <= (count_reg == '0) ? '0 : rd_data_reg;
            out_front_valid_reg <= (count_reg != '0);
            out_count_reg       <= count_reg;
            out_full_reg        <= (count_reg == CNT_W'(DEPTH));
        end
    end

    always_comb
    begin
        status.req        = req_reg;
        status.count_zero = (count_reg == '0);
        status.full       = (count_reg == CNT_W'(DEPTH));
        status.match      = (rd_data_reg == value_reg);
        status.scan_last  = ((CNT_W'(pos_reg) + 1'b1) == count_reg);
    end

    assign ok          = out_ok_reg;
    assign data_out    = out_data_reg;
    assign position    = POS_OUT_W'(out_pos_reg);
    assign front_value = out_front_reg;
    assign front_valid = out_front_valid_reg;
    assign count       = COUNT_OUT_W'(out_count_reg);
    assign full_res    = out_full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree for empty or full queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_write |-> count_reg < CNT_W'(DEPTH))
        else $error("write into full queue");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_next |-> (CNT_W'(pos_reg) + 1'b1) < count_reg)
        else $error("scan runs past occupied entries");

endmodule

`default_nettype wire

@@ src/fqs_ctrl.sv @@
// Controller state machine: sequences each request and owns the handshakes.
// Depends on fqs_pkg; commands fqs_dp and reads its status.
`default_nettype none

module fqs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire fqs_pkg::dp_status_t status,
    output fqs_pkg::ctrl_cmd_t       cmd
);
    import fqs_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FRONT_RD;
                case (status.req)
                    REQ_ENQUEUE:
                    begin
                        cmd.enq_write = !status.full;
                    end
                    REQ_DEQUEUE:
                    begin
                        if (!status.count_zero)
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = ST_DEQ_WAIT;
                        end
                    end
                    REQ_SEARCH, REQ_UPDATE:
                    begin
                        if (!status.count_zero)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_FRONT_RD;
                    end
                endcase
            end
            ST_DEQ_WAIT:
            begin
                cmd.deq_pop = 1'b1;
                state_next  = ST_FRONT_RD;
            end
            ST_SCAN:
            begin
                if (status.match)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = ST_FRONT_RD;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_FRONT_RD;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_FRONT_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_EXEC)
        else $error("accepted transaction not executed");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ src/fifo_queue_with_search.sv @@
// Top level of the FIFO queue with search and update: joins fqs_ctrl and fqs_dp.
// Depends on fqs_pkg, fqs_ctrl and fqs_dp.
// Path from acceptance to result valid: ST_IDLE accepts, ST_EXEC acts, ST_FRONT_RD reads
// the head and ST_RESP loads the result; dequeue on a non-empty queue adds ST_DEQ_WAIT,
// and search or update on a non-empty queue adds ST_SCAN over k (1..DEPTH) entries.
// One transaction in flight; ST_RESP waits on out_ready; scan reads one entry per cycle.
// Reset empties the queue; memory contents are not cleared and need no clearing pass.
`default_nettype none

module fifo_queue_with_search (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [fqs_pkg::REQ_W-1:0]           req_type,
    input  wire logic signed [fqs_pkg::DATA_W-1:0]   value,
    input  wire logic signed [fqs_pkg::DATA_W-1:0]   new_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     ok,
    output logic signed [fqs_pkg::DATA_W-1:0]        data_out,
    output logic [fqs_pkg::POS_OUT_W-1:0]            position,
    output logic signed [fqs_pkg::DATA_W-1:0]        front_value,
    output logic                                     front_valid,
    output logic [fqs_pkg::COUNT_OUT_W-1:0]          count,
    output logic                                     full_res
);
    import fqs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fqs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req_type),
        .value       (value),
        .new_value   (new_value),
        .ok          (ok),
        .data_out    (data_out),
        .position    (position),
        .front_value (front_value),
        .front_valid (front_valid),
        .count       (count),
        .full_res    (full_res)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for fifo_queue_with_search: directed table, then random traffic.
// Predicts every result with its own queue model and checks each result as it leaves.
// Depends on fqs_pkg and the fifo_queue_with_search RTL.
`default_nettype none

module tb;
    import fqs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
    localparam int RUN_LIMIT = 8_000_000;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data_out;
        logic [POS_OUT_W-1:0]     position;
        logic signed [DATA_W-1:0] front_value;
        logic                     front_valid;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     full_res;
    } queue_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]         req;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] repl;
        logic [4:0]               reps;
        logic                     fixed_want;
        queue_result_t            want;
    } stim_row_t;

    localparam queue_result_t EMPTY_RESULT = '0;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [REQ_W-1:0]         req_type = REQ_ENQUEUE;
    logic signed [DATA_W-1:0] value = '0;
    logic signed [DATA_W-1:0] new_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_OUT_W-1:0]     position;
    logic signed [DATA_W-1:0] front_value;
    logic                     front_valid;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     full_res;

    logic signed [DATA_W-1:0] q_store [DEPTH];
    int                       q_head = 0;
    int                       q_tail = 0;
    int                       q_count = 0;

    queue_result_t            pending_results [$];
    stim_row_t                directed_rows [17];
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       error_count = 0;
    int                       results_checked = 0;
    int                       full_refusals = 0;
    int                       scan_hits = 0;
    int                       op_seen [8] = '{default: 0};

    fifo_queue_with_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .data_out    (data_out),
        .position    (position),
        .front_value (front_value),
        .front_valid (front_valid),
        .count       (count),
        .full_res    (full_res)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("fifo_queue_with_search regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic queue_result_t apply_request(input logic [REQ_W-1:0] req,
                                                    input logic signed [DATA_W-1:0] key,
                                                    input logic signed [DATA_W-1:0] repl);
        queue_result_t r;
        int            hit_pos;
        int            slot;
        int            k;
        r = '0;
        hit_pos = -1;
        slot = 0;
        if (req == REQ_SEARCH || req == REQ_UPDATE)
        begin
            for (k = 0; k < q_count; k++)
            begin
                if (hit_pos < 0 && q_store[(q_head + k) % DEPTH] == key)
                begin
                    hit_pos = k;
                    slot = (q_head + k) % DEPTH;
                end
            end
        end
        case (req)
            REQ_ENQUEUE:
            begin
                if (q_count < DEPTH)
                begin
                    q_store[q_tail] = key;
                    q_tail = (q_tail + 1) % DEPTH;
                    q_count++;
                    r.ok = 1'b1;
                end
            end
            REQ_DEQUEUE:
            begin
                if (q_count > 0)
                begin
                    r.data_out = q_store[q_head];
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    r.ok = 1'b1;
                end
            end
            REQ_SEARCH:
            begin
                if (hit_pos >= 0)
                begin
                    r.ok = 1'b1;
                    r.position = POS_OUT_W'(hit_pos);
                end
            end
            REQ_UPDATE:
            begin
                if (hit_pos >= 0)
                begin
                    q_store[slot] = repl;
                    r.ok = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                q_head = 0;
                q_tail = 0;
                q_count = 0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.front_valid = (q_count > 0);
        r.front_value = (q_count > 0) ? q_store[q_head] : '0;
        r.count = COUNT_OUT_W'(q_count);
        r.full_res = (q_count == DEPTH);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        int                       sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            v = $urandom_range(0, 6);
            v = v - 32'sd3;
        end
        else if (sel < 55)
        begin
            case ($urandom_range(0, 3))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = '0;
                default: v = -32'sd1;
            endcase
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        int offset;
        if (q_count > 0 && $urandom_range(0, 99) < 70)
        begin
            offset = $urandom_range(0, q_count - 1);
            return q_store[(q_head + offset) % DEPTH];
        end
        return pick_value();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_checked, msg);
        error_count++;
    endtask

    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic signed [DATA_W-1:0] key,
                                input logic signed [DATA_W-1:0] repl,
                                input logic use_fixed,
                                input queue_result_t fixed);
        queue_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value <= key;
        new_value <= repl;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predicted = apply_request(req, key, repl);
        pending_results.push_back(use_fixed ? fixed : predicted);
        op_seen[req]++;
        if (req == REQ_ENQUEUE && !predicted.ok)
        begin
            full_refusals++;
        end
        if ((req == REQ_SEARCH || req == REQ_UPDATE) && predicted.ok)
        begin
            scan_hits++;
        end
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no transaction pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch($sformatf("ok got %b expected %b", ok, want.ok));
                if (data_out !== want.data_out)
                    report_mismatch($sformatf("data_out got %h expected %h",
                                              data_out, want.data_out));
                if (position !== want.position)
                    report_mismatch($sformatf("position got %0d expected %0d",
                                              position, want.position));
                if (front_value !== want.front_value)
                    report_mismatch($sformatf("front_value got %h expected %h",
                                              front_value, want.front_value));
                if (front_valid !== want.front_valid)
                    report_mismatch($sformatf("front_valid got %b expected %b",
                                              front_valid, want.front_valid));
                if (count !== want.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              count, want.count));
                if (full_res !== want.full_res)
                    report_mismatch($sformatf("full_res got %b expected %b",
                                              full_res, want.full_res));
                results_checked++;
            end
        end
    end

    initial
    begin
        logic [REQ_W-1:0]         req;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] repl;
        bit                       trend_up;
        int                       sel;
        int                       phase;
        int                       i;
        int                       c;
        int                       unused_ops;

        directed_rows = '{
            '{REQ_DEQUEUE, 32'sd0, 32'sd0, 5'd1, 1'b1, EMPTY_RESULT},
            '{REQ_UPDATE, 32'sd0, 32'sd1, 5'd1, 1'b1, EMPTY_RESULT},
            '{REQ_RSVD_LO, VAL_MAX, VAL_MIN, 5'd1, 1'b1, EMPTY_RESULT},
            '{REQ_ENQUEUE, VAL_MIN, 32'sd0, 5'd1, 1'b1,
              '{1'b1, 32'sd0, 4'd0, VAL_MIN, 1'b1, 5'd1, 1'b0}},
            '{REQ_ENQUEUE, VAL_MAX, 32'sd0, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_ENQUEUE, -32'sd1, 32'sd0, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_ENQUEUE, 32'sd5, 32'sd0, 5'd13, 1'b0, EMPTY_RESULT},
            '{REQ_ENQUEUE, 32'sd7, 32'sd0, 5'd1, 1'b1,
              '{1'b0, 32'sd0, 4'd0, VAL_MIN, 1'b1, COUNT_OUT_W'(DEPTH), 1'b1}},
            '{REQ_SEARCH, 32'sd5, 32'sd0, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_UPDATE, 32'sd5, 32'sd9, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_SEARCH, 32'sd5, 32'sd0, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_SEARCH, 32'sd0, 32'sd0, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_UPDATE, 32'sd123, 32'sd0, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_DEQUEUE, 32'sd0, 32'sd0, 5'd1, 1'b1,
              '{1'b1, VAL_MIN, 4'd0, VAL_MAX, 1'b1, COUNT_OUT_W'(DEPTH - 1), 1'b0}},
            '{REQ_UPDATE, VAL_MAX, VAL_MIN, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_RSVD_HI, -32'sd1, -32'sd1, 5'd1, 1'b0, EMPTY_RESULT},
            '{REQ_CLEAR, 32'sd0, 32'sd0, 5'd1, 1'b1,
              '{1'b1, 32'sd0, 4'd0, 32'sd0, 1'b0, 5'd0, 1'b0}}
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 84;
        foreach (directed_rows[r])
        begin
            repeat (directed_rows[r].reps)
                send_request(directed_rows[r].req, directed_rows[r].key,
                             directed_rows[r].repl, directed_rows[r].fixed_want,
                             directed_rows[r].want);
        end
        in_valid <= 1'b0;
        wait_for_drain();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 35 : 0;
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                trend_up = ((i / 40) % 2 == 0);
                sel = $urandom_range(0, 99);
                if (sel < (trend_up ? 50 : 15))
                    req = REQ_ENQUEUE;
                else if (sel < (trend_up ? 65 : 55))
                    req = REQ_DEQUEUE;
                else if (sel < (trend_up ? 80 : 75))
                    req = REQ_SEARCH;
                else if (sel < 92)
                    req = REQ_UPDATE;
                else if (sel < 95)
                    req = REQ_CLEAR;
                else
                    req = REQ_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
                key = (req == REQ_SEARCH || req == REQ_UPDATE) ? pick_key() : pick_value();
                repl = pick_value();
                send_request(req, key, repl, 1'b0, EMPTY_RESULT);
            end
            in_valid <= 1'b0;
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);

        unused_ops = 0;
        for (c = REQ_RSVD_LO; c <= REQ_RSVD_HI; c++)
            unused_ops += op_seen[c];
        $display("covered %0d enqueue, %0d dequeue, %0d search, %0d update, %0d clear, %0d unused",
                 op_seen[REQ_ENQUEUE], op_seen[REQ_DEQUEUE], op_seen[REQ_SEARCH],
                 op_seen[REQ_UPDATE], op_seen[REQ_CLEAR], unused_ops);
        $display("%0d results checked, %0d refused on full, %0d scan hits, %0d mismatches",
                 results_checked, full_refusals, scan_hits, error_count);
        if (error_count == 0)
            $display("fifo_queue_with_search regression: pass");
        else
            $display("fifo_queue_with_search regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
